FILE: rtl/core/svp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp_pkg
// Shared types and constants of the stereo sample-playback voice: opcodes,
// register indexes, the command that travels from the front to the back,
// and the configuration bundle.
// ----------------------------------------------------------------------------
package svp_pkg;

	// Store depth used when the top level is not told otherwise.
	localparam int DEF_MAX_FRAMES = 65536;

	// Width of the read position and of the frame count register.
	localparam int POS_W = 17;

	// Largest value the frame count register can hold.
	localparam int COUNT_MAX = 131071;

	// Widths of the item fields.
	localparam int ADDR_W   = 16;
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;

	// Q1.15 unity gain.
	localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h8000;

	// Depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Opcodes of an input item.
	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_RENDER = 2'd1,
		OP_PLAY   = 2'd2,
		OP_VOLUME = 2'd3
	} opcode_t;

	// Register indexes of the configuration port.
	typedef enum logic {
		REG_LOOP_ENABLE = 1'b0,
		REG_FRAME_COUNT = 1'b1
	} reg_idx_t;

	// Work handed to the back end.
	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_SILENT = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [POS_W-1:0]      addr;
		logic [2*SAMPLE_W-1:0] data;
		logic [GAIN_W-1:0]     gain;
		logic                  playing_now;
		logic                  ended_here;
	} cmd_t;

	// Configuration registers as seen by the front end.
	typedef struct packed {
		logic             loop_enable;
		logic [POS_W-1:0] frame_count;
	} cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/svp_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp channels
// Valid/ready channels of the voice: the item channel into the block and
// the result channel out of it.
// ----------------------------------------------------------------------------
interface svp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] frame_address;
	logic signed [15:0] left_in;
	logic signed [15:0] right_in;
	logic        play_enable;
	logic        restart_flag;
	logic [15:0] volume_level;

	modport source (
		output valid, opcode, frame_address, left_in, right_in,
		       play_enable, restart_flag, volume_level,
		input  ready
	);
	modport sink (
		input  valid, opcode, frame_address, left_in, right_in,
		       play_enable, restart_flag, volume_level,
		output ready
	);
endinterface

interface svp_out_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic        playing_now;
	logic        ended_here;

	modport source (
		output valid, left_out, right_out, playing_now, ended_here,
		input  ready
	);
	modport sink (
		input  valid, left_out, right_out, playing_now, ended_here,
		output ready
	);
endinterface
`default_nettype wire

FILE: rtl/core/svp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp_front
// Accepts items, keeps the playback state (position, play flag, gain) and
// turns each render item and each in-range load item into a back-end command.
// ----------------------------------------------------------------------------
module svp_front #(
	parameter int MAX_FRAMES = svp_pkg::DEF_MAX_FRAMES
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	svp_in_if.sink             items,
	input  wire svp_pkg::cfg_t cfg,
	input  wire logic          queue_full,
	output      logic          push,
	output      svp_pkg::cmd_t cmd
);
	import svp_pkg::*;

	// Frames the store can hold; load addresses are 16 bits wide.
	localparam int STORE_DEPTH = (MAX_FRAMES < 65536) ? MAX_FRAMES : 65536;
	localparam logic [POS_W-1:0] STORE_LIMIT = POS_W'(STORE_DEPTH);
	// Largest usable frame count.
	localparam logic [POS_W-1:0] COUNT_CAP =
		POS_W'((MAX_FRAMES < COUNT_MAX) ? MAX_FRAMES : COUNT_MAX);
	localparam logic [POS_W-1:0] ONE = POS_W'(1);

	logic [POS_W-1:0]  pos_q, pos_d;
	logic              playing_q, playing_d;
	logic [GAIN_W-1:0] gain_q, gain_d;
	logic [POS_W-1:0]  count;
	logic [POS_W-1:0]  start_pos, next_pos;
	logic              at_end;
	logic              accept;

	assign items.ready = !queue_full;
	assign accept      = items.valid && items.ready;

	// Frame count clamped to the range the store supports.
	always_comb begin
		if (cfg.frame_count == '0) begin
			count = ONE;
		end else if (cfg.frame_count > COUNT_CAP) begin
			count = COUNT_CAP;
		end else begin
			count = cfg.frame_count;
		end
	end

	// Position handling of a render step.
	assign at_end    = pos_q >= count;
	assign start_pos = at_end ? '0 : pos_q;
	assign next_pos  = start_pos + ONE;

	// Classify the item and work out the next state.
	always_comb begin
		pos_d            = pos_q;
		playing_d        = playing_q;
		gain_d           = gain_q;
		push             = 1'b0;
		cmd.kind         = CMD_SILENT;
		cmd.addr         = start_pos;
		cmd.data         = {items.right_in, items.left_in};
		cmd.gain         = gain_q;
		cmd.playing_now  = 1'b0;
		cmd.ended_here   = 1'b0;
		if (accept) begin
			case (opcode_t'(items.opcode))
				OP_LOAD: begin
					cmd.kind = CMD_WRITE;
					cmd.addr = {1'b0, items.frame_address};
					push     = {1'b0, items.frame_address} < STORE_LIMIT;
				end
				OP_RENDER: begin
					push = 1'b1;
					if (!playing_q) begin
						cmd.kind = CMD_SILENT;
					end else if (at_end && !cfg.loop_enable) begin
						cmd.kind       = CMD_SILENT;
						cmd.ended_here = 1'b1;
						playing_d      = 1'b0;
					end else begin
						cmd.kind = CMD_READ;
						if (next_pos >= count) begin
							if (cfg.loop_enable) begin
								pos_d = '0;
							end else begin
								pos_d          = next_pos;
								playing_d      = 1'b0;
								cmd.ended_here = 1'b1;
							end
						end else begin
							pos_d = next_pos;
						end
						cmd.playing_now = playing_d;
					end
				end
				OP_PLAY: begin
					if (items.restart_flag) begin
						pos_d = '0;
					end
					playing_d = items.play_enable;
				end
				OP_VOLUME: begin
					gain_d = (items.volume_level > UNITY_GAIN) ? UNITY_GAIN
					                                           : items.volume_level;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	// Playback state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			playing_q <= 1'b0;
			gain_q    <= UNITY_GAIN;
		end else begin
			pos_q     <= pos_d;
			playing_q <= playing_d;
			gain_q    <= gain_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/svp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp_queue
// Short command queue between front and back, so that each side can stall
// without holding up the other.
// ----------------------------------------------------------------------------
module svp_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire svp_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output      svp_pkg::cmd_t head,
	output      logic          full,
	output      logic          empty
);
	import svp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W+1)'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

	cmd_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   fill_q;
	logic             do_push, do_pop;

	assign full    = fill_q == DEPTH_CNT;
	assign empty   = fill_q == '0;
	assign head    = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Command storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + (PTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (PTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/svp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp_back
// Carries out commands: writes or reads the sample store, scales the frame
// by the gain and presents the result beat in an output register.
// ----------------------------------------------------------------------------
module svp_back #(
	parameter int MAX_FRAMES = svp_pkg::DEF_MAX_FRAMES
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire svp_pkg::cmd_t head,
	input  wire logic          empty,
	output      logic          pop,
	svp_out_if.source          results
);
	import svp_pkg::*;

	localparam int STORE_DEPTH = (MAX_FRAMES < 65536) ? MAX_FRAMES : 65536;
	localparam int AW = $clog2(STORE_DEPTH);

	logic [2*SAMPLE_W-1:0] store [STORE_DEPTH];

	logic                  advance;
	logic [AW-1:0]         index;

	// Stage 1: store read.
	logic                  valid_s1;
	logic                  silent_s1;
	logic [2*SAMPLE_W-1:0] frame_s1;
	logic [GAIN_W-1:0]     gain_s1;
	logic                  playing_s1;
	logic                  ended_s1;

	// Stage 2: products.
	logic                  valid_s2;
	logic signed [31:0]    prod_l_s2, prod_r_s2;
	logic                  playing_s2;
	logic                  ended_s2;

	// Output register.
	logic                  out_valid_q;
	logic signed [15:0]    left_q, right_q;
	logic                  playing_q, ended_q;

	logic signed [SAMPLE_W-1:0] samp_l, samp_r;
	logic signed [GAIN_W:0]     gain_signed;
	logic signed [32:0]         prod_l, prod_r;

	// The whole pipeline moves when the output register is free or drained.
	assign advance = !out_valid_q || results.ready;
	assign pop     = advance && !empty;
	assign index   = head.addr[AW-1:0];

	// Sample store: at most one write or one read per command.
	always_ff @(posedge clk) begin
		if (pop) begin
			case (head.kind)
				CMD_WRITE: store[index] <= head.data;
				CMD_READ:  frame_s1 <= store[index];
				default:   ;
			endcase
		end
	end

	// Stage 1 side data.
	always_ff @(posedge clk) begin
		if (advance) begin
			silent_s1  <= head.kind != CMD_READ;
			gain_s1    <= head.gain;
			playing_s1 <= head.playing_now;
			ended_s1   <= head.ended_here;
		end
	end

	// Scale both channels; a silent beat multiplies zero.
	assign samp_l      = silent_s1 ? '0 : frame_s1[SAMPLE_W-1:0];
	assign samp_r      = silent_s1 ? '0 : frame_s1[2*SAMPLE_W-1:SAMPLE_W];
	assign gain_signed = {1'b0, gain_s1};
	assign prod_l      = samp_l * gain_signed;
	assign prod_r      = samp_r * gain_signed;

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_l_s2  <= prod_l[31:0];
			prod_r_s2  <= prod_r[31:0];
			playing_s2 <= playing_s1;
			ended_s2   <= ended_s1;
		end
	end

	// Arithmetic shift right by 15 into the output register.
	always_ff @(posedge clk) begin
		if (advance) begin
			left_q    <= prod_l_s2[30:15];
			right_q   <= prod_r_s2[30:15];
			playing_q <= playing_s2;
			ended_q   <= ended_s2;
		end
	end

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= pop && (head.kind != CMD_WRITE);
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.left_out    = left_q;
	assign results.right_out   = right_q;
	assign results.playing_now = playing_q;
	assign results.ended_here  = ended_q;

endmodule
`default_nettype wire

FILE: rtl/core/sample_playback_voice_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sample_playback_voice_top
// A render item's result beat passes the queue, the store read, the multiply
// and the output register in turn.
// Throughput: one item per cycle while the queue is not full, bounded by the single store port.
// Reset: arst_n clears position, play flag, queue and pipeline valids, sets
// unity gain, loop off and frame count 1; the sample store is not cleared.
// ----------------------------------------------------------------------------
module sample_playback_voice_top #(
	parameter int MAX_FRAMES = svp_pkg::DEF_MAX_FRAMES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	svp_in_if.sink           items,
	svp_out_if.source        results,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);
	import svp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_write;
	logic     push, pop, queue_full, queue_empty;
	cmd_t     push_cmd, head;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loop_enable <= 1'b0;
			cfg_q.frame_count <= POS_W'(1);
		end else if (cfg_write) begin
			case (reg_idx)
				REG_LOOP_ENABLE: cfg_q.loop_enable <= pwdata[0];
				REG_FRAME_COUNT: cfg_q.frame_count <= pwdata[POS_W-1:0];
				default:         ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (reg_idx)
			REG_LOOP_ENABLE: prdata = {31'b0, cfg_q.loop_enable};
			REG_FRAME_COUNT: prdata = {{(32-POS_W){1'b0}}, cfg_q.frame_count};
			default:         prdata = '0;
		endcase
	end

	svp_front #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.cfg        (cfg_q),
		.queue_full (queue_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	svp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	svp_back #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (queue_empty),
		.pop     (pop),
		.results (results)
	);

endmodule
`default_nettype wire
